### src/ffs_pkg.sv
`default_nettype none
package ffs_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 28;
  localparam int BATCH_ITERS = 8;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int NUM_W  = WORD_BITS + FRAC_BITS;
  localparam int PC_W   = 6;
  localparam int ITER_W = (BATCH_ITERS > 1) ? $clog2(BATCH_ITERS) : 1;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_VAL = (FRAC_BITS >= WORD_BITS - 1) ? WMAX :
                              word_t'(64'd1 << FRAC_BITS);

  localparam logic [3:0] F_MANDEL  = 4'd0;
  localparam logic [3:0] F_SHIP    = 4'd1;
  localparam logic [3:0] F_BUFFALO = 4'd2;
  localparam logic [3:0] F_CUBIC   = 4'd3;
  localparam logic [3:0] F_QUAD    = 4'd4;
  localparam logic [3:0] F_BARN1   = 4'd5;
  localparam logic [3:0] F_BARN2   = 4'd6;
  localparam logic [3:0] F_LAMBDA  = 4'd7;
  localparam logic [3:0] F_NOVA    = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_FSEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QB   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QK   = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_DIV0 = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_ABS, OP_DIV, OP_MOV, OP_TST, OP_NZ
  } op_e;

  typedef enum logic [1:0] {G_ALL, G_POS, G_NEG} guard_e;

  typedef enum logic [4:0] {
    R_X, R_Y, R_CX, R_CY, R_SX, R_SY, R_QA, R_QB, R_QK, R_ONE,
    R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7
  } reg_e;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE} state_e;

  typedef struct packed {
    op_e    op;
    guard_e guard;
    reg_e   dst;
    reg_e   src_a;
    reg_e   src_b;
    logic   last;
  } uop_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul_wb;
    logic publish;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic       abort;
    logic       div_done;
    logic       out_busy;
    logic [3:0] fsel;
  } stat_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } res_t;

  function automatic res_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    res_t r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    r.ovf = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.val = r.ovf ? (s[WORD_BITS] ? WMIN : WMAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic res_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    res_t r;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    r.ovf = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.val = r.ovf ? (s[WORD_BITS] ? WMIN : WMAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic uop_t mk(op_e op, reg_e d, reg_e a, reg_e b, guard_e g, logic last);
    uop_t u;
    u.op = op;
    u.dst = d;
    u.src_a = a;
    u.src_b = b;
    u.guard = g;
    u.last = last;
    return u;
  endfunction

  function automatic uop_t u(op_e op, reg_e d, reg_e a, reg_e b);
    return mk(op, d, a, b, G_ALL, 1'b0);
  endfunction

  function automatic uop_t ul(reg_e d, reg_e a);
    return mk(OP_MOV, d, a, a, G_ALL, 1'b1);
  endfunction

  localparam uop_t U_END = '{op: OP_NOP, guard: G_ALL, dst: R_T0, src_a: R_T0,
                             src_b: R_T0, last: 1'b1};

  // microprogram, one sequence per formula; the two Barnsley formulas share one
  function automatic uop_t ucode(logic [3:0] fsel, logic [PC_W-1:0] pc);
    uop_t r;
    r = U_END;
    case (fsel)
      F_MANDEL: begin
        case (pc)
          6'd0:  r = u(OP_MUL, R_T0, R_X, R_X);
          6'd1:  r = u(OP_MUL, R_T1, R_Y, R_Y);
          6'd2:  r = u(OP_MOV, R_SX, R_T0, R_T0);
          6'd3:  r = u(OP_MOV, R_SY, R_T1, R_T1);
          6'd4:  r = u(OP_SUB, R_T2, R_T0, R_T1);
          6'd5:  r = u(OP_ADD, R_T2, R_T2, R_CX);
          6'd6:  r = u(OP_MUL, R_T3, R_X, R_Y);
          6'd7:  r = u(OP_ADD, R_T3, R_T3, R_T3);
          6'd8:  r = u(OP_ADD, R_T3, R_T3, R_CY);
          6'd9:  r = u(OP_MOV, R_X, R_T2, R_T2);
          default: r = ul(R_Y, R_T3);
        endcase
      end
      F_SHIP: begin
        case (pc)
          6'd0:  r = u(OP_ABS, R_T6, R_X, R_X);
          6'd1:  r = u(OP_ABS, R_T7, R_Y, R_Y);
          6'd2:  r = u(OP_MUL, R_T0, R_T6, R_T6);
          6'd3:  r = u(OP_MUL, R_T1, R_T7, R_T7);
          6'd4:  r = u(OP_MOV, R_SX, R_T0, R_T0);
          6'd5:  r = u(OP_MOV, R_SY, R_T1, R_T1);
          6'd6:  r = u(OP_SUB, R_T2, R_T0, R_T1);
          6'd7:  r = u(OP_ADD, R_T2, R_T2, R_CX);
          6'd8:  r = u(OP_MUL, R_T3, R_T6, R_T7);
          6'd9:  r = u(OP_ADD, R_T3, R_T3, R_T3);
          6'd10: r = u(OP_ADD, R_T3, R_T3, R_CY);
          6'd11: r = u(OP_MOV, R_X, R_T2, R_T2);
          default: r = ul(R_Y, R_T3);
        endcase
      end
      F_BUFFALO: begin
        case (pc)
          6'd0:  r = u(OP_ABS, R_T6, R_X, R_X);
          6'd1:  r = u(OP_ABS, R_T7, R_Y, R_Y);
          6'd2:  r = u(OP_MUL, R_T0, R_T6, R_T6);
          6'd3:  r = u(OP_MUL, R_T1, R_T7, R_T7);
          6'd4:  r = u(OP_MOV, R_SX, R_T0, R_T0);
          6'd5:  r = u(OP_MOV, R_SY, R_T1, R_T1);
          6'd6:  r = u(OP_SUB, R_T2, R_T0, R_T1);
          6'd7:  r = u(OP_SUB, R_T2, R_T2, R_T6);
          6'd8:  r = u(OP_ADD, R_T2, R_T2, R_CX);
          6'd9:  r = u(OP_MUL, R_T3, R_T6, R_T7);
          6'd10: r = u(OP_ADD, R_T3, R_T3, R_T3);
          6'd11: r = u(OP_SUB, R_T3, R_T3, R_T7);
          6'd12: r = u(OP_ADD, R_T3, R_T3, R_CY);
          6'd13: r = u(OP_MOV, R_X, R_T2, R_T2);
          default: r = ul(R_Y, R_T3);
        endcase
      end
      F_CUBIC: begin
        case (pc)
          6'd0:  r = u(OP_MUL, R_T0, R_X, R_X);
          6'd1:  r = u(OP_MUL, R_T1, R_Y, R_Y);
          6'd2:  r = u(OP_MOV, R_SX, R_T0, R_T0);
          6'd3:  r = u(OP_MOV, R_SY, R_T1, R_T1);
          6'd4:  r = u(OP_MUL, R_T2, R_T0, R_X);
          6'd5:  r = u(OP_MUL, R_T3, R_X, R_T1);
          6'd6:  r = u(OP_ADD, R_T4, R_T3, R_T3);
          6'd7:  r = u(OP_ADD, R_T4, R_T4, R_T3);
          6'd8:  r = u(OP_SUB, R_T2, R_T2, R_T4);
          6'd9:  r = u(OP_ADD, R_T2, R_T2, R_CX);
          6'd10: r = u(OP_MUL, R_T3, R_T0, R_Y);
          6'd11: r = u(OP_ADD, R_T4, R_T3, R_T3);
          6'd12: r = u(OP_ADD, R_T4, R_T4, R_T3);
          6'd13: r = u(OP_MUL, R_T5, R_T1, R_Y);
          6'd14: r = u(OP_SUB, R_T4, R_T4, R_T5);
          6'd15: r = u(OP_ADD, R_T4, R_T4, R_CY);
          6'd16: r = u(OP_MOV, R_X, R_T2, R_T2);
          default: r = ul(R_Y, R_T4);
        endcase
      end
      F_QUAD: begin
        case (pc)
          6'd0:  r = u(OP_MUL, R_T0, R_X, R_X);
          6'd1:  r = u(OP_MUL, R_T1, R_Y, R_Y);
          6'd2:  r = u(OP_MOV, R_SX, R_T0, R_T0);
          6'd3:  r = u(OP_MOV, R_SY, R_T1, R_T1);
          6'd4:  r = u(OP_SUB, R_T2, R_T0, R_T1);
          6'd5:  r = u(OP_MUL, R_T2, R_QA, R_T2);
          6'd6:  r = u(OP_MUL, R_T3, R_QB, R_X);
          6'd7:  r = u(OP_ADD, R_T2, R_T2, R_T3);
          6'd8:  r = u(OP_MUL, R_T3, R_QK, R_CX);
          6'd9:  r = u(OP_ADD, R_T2, R_T2, R_T3);
          6'd10: r = u(OP_MUL, R_T3, R_X, R_Y);
          6'd11: r = u(OP_ADD, R_T3, R_T3, R_T3);
          6'd12: r = u(OP_MUL, R_T3, R_QA, R_T3);
          6'd13: r = u(OP_MUL, R_T4, R_QB, R_Y);
          6'd14: r = u(OP_ADD, R_T3, R_T3, R_T4);
          6'd15: r = u(OP_MUL, R_T4, R_QK, R_CY);
          6'd16: r = u(OP_ADD, R_T3, R_T3, R_T4);
          6'd17: r = u(OP_MOV, R_X, R_T2, R_T2);
          default: r = ul(R_Y, R_T3);
        endcase
      end
      F_BARN1, F_BARN2: begin
        case (pc)
          6'd0:  r = u(OP_MUL, R_T0, R_X, R_CY);
          6'd1:  r = u(OP_MUL, R_T1, R_X, R_CX);
          6'd2:  r = u(OP_MUL, R_T2, R_Y, R_CY);
          6'd3:  r = u(OP_MUL, R_T3, R_Y, R_CX);
          6'd4:  r = (fsel == F_BARN1) ? u(OP_NOP, R_T4, R_T4, R_T4)
                                       : u(OP_ADD, R_T4, R_T0, R_T3);
          6'd5:  r = (fsel == F_BARN1) ? u(OP_TST, R_T4, R_X, R_X)
                                       : u(OP_TST, R_T4, R_T4, R_T4);
          6'd6:  r = mk(OP_SUB, R_T4, R_T1, R_CX, G_POS, 1'b0);
          6'd7:  r = mk(OP_ADD, R_T4, R_T1, R_CX, G_NEG, 1'b0);
          6'd8:  r = u(OP_SUB, R_T4, R_T4, R_T2);
          6'd9:  r = mk(OP_SUB, R_T5, R_T3, R_CY, G_POS, 1'b0);
          6'd10: r = mk(OP_ADD, R_T5, R_T3, R_CY, G_NEG, 1'b0);
          6'd11: r = u(OP_ADD, R_T5, R_T5, R_T0);
          6'd12: r = u(OP_MOV, R_X, R_T4, R_T4);
          default: r = ul(R_Y, R_T5);
        endcase
      end
      F_LAMBDA: begin
        case (pc)
          6'd0:  r = u(OP_MUL, R_T0, R_X, R_X);
          6'd1:  r = u(OP_MUL, R_T1, R_Y, R_Y);
          6'd2:  r = u(OP_MOV, R_SX, R_T0, R_T0);
          6'd3:  r = u(OP_MOV, R_SY, R_T1, R_T1);
          6'd4:  r = u(OP_SUB, R_T2, R_X, R_T0);
          6'd5:  r = u(OP_ADD, R_T2, R_T2, R_T1);
          6'd6:  r = u(OP_MUL, R_T3, R_X, R_Y);
          6'd7:  r = u(OP_ADD, R_T3, R_T3, R_T3);
          6'd8:  r = u(OP_SUB, R_T3, R_Y, R_T3);
          6'd9:  r = u(OP_MUL, R_T4, R_CX, R_T2);
          6'd10: r = u(OP_MUL, R_T5, R_CY, R_T3);
          6'd11: r = u(OP_SUB, R_T4, R_T4, R_T5);
          6'd12: r = u(OP_MUL, R_T5, R_CX, R_T3);
          6'd13: r = u(OP_MUL, R_T6, R_CY, R_T2);
          6'd14: r = u(OP_ADD, R_T5, R_T5, R_T6);
          6'd15: r = u(OP_MOV, R_X, R_T4, R_T4);
          default: r = ul(R_Y, R_T5);
        endcase
      end
      F_NOVA: begin
        case (pc)
          6'd0:  r = u(OP_MUL, R_T0, R_X, R_X);
          6'd1:  r = u(OP_MUL, R_T1, R_Y, R_Y);
          6'd2:  r = u(OP_SUB, R_T0, R_T0, R_T1);
          6'd3:  r = u(OP_MUL, R_T1, R_X, R_Y);
          6'd4:  r = u(OP_ADD, R_T1, R_T1, R_T1);
          6'd5:  r = u(OP_MUL, R_T2, R_T0, R_X);
          6'd6:  r = u(OP_MUL, R_T3, R_T1, R_Y);
          6'd7:  r = u(OP_SUB, R_T2, R_T2, R_T3);
          6'd8:  r = u(OP_MUL, R_T3, R_T0, R_Y);
          6'd9:  r = u(OP_MUL, R_T4, R_T1, R_X);
          6'd10: r = u(OP_ADD, R_T3, R_T3, R_T4);
          6'd11: r = u(OP_SUB, R_T2, R_T2, R_ONE);
          6'd12: r = u(OP_ADD, R_T4, R_T0, R_T0);
          6'd13: r = u(OP_ADD, R_T4, R_T4, R_T0);
          6'd14: r = u(OP_ADD, R_T5, R_T1, R_T1);
          6'd15: r = u(OP_ADD, R_T5, R_T5, R_T1);
          6'd16: r = u(OP_MUL, R_T0, R_T4, R_T4);
          6'd17: r = u(OP_MUL, R_T1, R_T5, R_T5);
          6'd18: r = u(OP_ADD, R_T0, R_T0, R_T1);
          6'd19: r = u(OP_NZ, R_T0, R_T0, R_T0);
          6'd20: r = u(OP_MUL, R_T1, R_T2, R_T4);
          6'd21: r = u(OP_MUL, R_T6, R_T3, R_T5);
          6'd22: r = u(OP_ADD, R_T1, R_T1, R_T6);
          6'd23: r = u(OP_DIV, R_T1, R_T1, R_T0);
          6'd24: r = u(OP_MUL, R_T6, R_T3, R_T4);
          6'd25: r = u(OP_MUL, R_T7, R_T2, R_T5);
          6'd26: r = u(OP_SUB, R_T6, R_T6, R_T7);
          6'd27: r = u(OP_DIV, R_T6, R_T6, R_T0);
          6'd28: r = u(OP_SUB, R_T1, R_X, R_T1);
          6'd29: r = u(OP_ADD, R_T1, R_T1, R_CX);
          6'd30: r = u(OP_SUB, R_T6, R_Y, R_T6);
          6'd31: r = u(OP_ADD, R_T6, R_T6, R_CY);
          6'd32: r = u(OP_MOV, R_X, R_T1, R_T1);
          default: r = ul(R_Y, R_T6);
        endcase
      end
      default: r = U_END;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/ffs_div.sv
`default_nettype none
module ffs_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire ffs_pkg::word_t  num_i,
  input  wire ffs_pkg::word_t  den_i,
  output logic                 done_o,
  output ffs_pkg::word_t       quo_o,
  output logic                 sat_o
);
  import ffs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NUM_W-1:0]      sr_q, sr_d;
  logic [WORD_BITS-1:0]  rem_q, rem_d;
  logic [WORD_BITS-1:0]  den_q;
  logic                  neg_q;
  logic                  done_q;
  word_t                 quo_q;
  logic                  sat_q;
  logic [WORD_BITS-1:0]  mag;
  logic [WORD_BITS:0]    rs;
  logic                  qbit;
  logic                  over;

  assign mag  = num_i[WORD_BITS-1] ? (~num_i + 1'b1) : num_i;
  assign rs   = {rem_q, sr_q[NUM_W-1]};
  assign qbit = rs >= {1'b0, den_q};
  assign over = |sr_d[NUM_W-1:WORD_BITS-1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sr_d   = sr_q;
    rem_d  = rem_q;
    if (busy_q) begin
      rem_d = qbit ? WORD_BITS'(rs - {1'b0, den_q}) : rs[WORD_BITS-1:0];
      sr_d  = {sr_q[NUM_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !busy_d;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else begin
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sr_q  <= {mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[WORD_BITS-1];
    end else begin
      sr_q  <= sr_d;
      rem_q <= rem_d;
      if (busy_q && !busy_d) begin
        sat_q <= over;
        if (over) quo_q <= neg_q ? WMIN : WMAX;
        else quo_q <= neg_q ? word_t'(~sr_d[WORD_BITS-1:0] + 1'b1)
                            : word_t'(sr_d[WORD_BITS-1:0]);
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign sat_o  = sat_q;

endmodule
`default_nettype wire

### src/ffs_dp.sv
`default_nettype none
module ffs_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ffs_pkg::cmd_t                  cmd_i,
  output ffs_pkg::stat_t                      stat_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ffs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire ffs_pkg::word_t                 cfg_data_i,
  input  wire ffs_pkg::word_t                 z_real_in_i,
  input  wire ffs_pkg::word_t                 z_imag_in_i,
  input  wire ffs_pkg::word_t                 c_real_i,
  input  wire ffs_pkg::word_t                 c_imag_i,
  input  wire ffs_pkg::word_t                 sq_real_in_i,
  input  wire ffs_pkg::word_t                 sq_imag_in_i,
  output ffs_pkg::word_t                      z_real_out_o,
  output ffs_pkg::word_t                      z_imag_out_o,
  output ffs_pkg::word_t                      sq_real_out_o,
  output ffs_pkg::word_t                      sq_imag_out_o,
  output logic [1:0]                          status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i
);
  import ffs_pkg::*;

  localparam int RND_W = PROD_W + 1;
  localparam int SH_W  = RND_W - FRAC_BITS;

  logic [3:0] fsel_q;
  word_t qa_q, qb_q, qk_q;
  word_t x_q, y_q, cx_q, cy_q, sx_q, sy_q;
  word_t t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q;
  logic signed [PROD_W-1:0] prod_q;
  reg_e  dst_q;
  logic  cond_q, sat_q, div0_q;
  word_t zr_o_q, zi_o_q, sr_o_q, si_o_q;
  logic [1:0] st_o_q;
  logic  ovalid_q;

  uop_t  uop;
  word_t a, b;
  res_t  add_r, sub_r, alu_r;
  logic  guard_ok;
  logic  wr_en;
  reg_e  wr_sel;
  word_t wr_val;
  logic  wr_ovf;
  logic signed [RND_W-1:0] rnd;
  logic signed [SH_W-1:0]  shv;
  res_t  mul_r;
  logic  div_start, div_done, div_sat;
  word_t div_quo;

  function automatic word_t rd(reg_e r);
    word_t v;
    case (r)
      R_X:  v = x_q;
      R_Y:  v = y_q;
      R_CX: v = cx_q;
      R_CY: v = cy_q;
      R_SX: v = sx_q;
      R_SY: v = sy_q;
      R_QA: v = qa_q;
      R_QB: v = qb_q;
      R_QK: v = qk_q;
      R_ONE: v = ONE_VAL;
      R_T0: v = t0_q;
      R_T1: v = t1_q;
      R_T2: v = t2_q;
      R_T3: v = t3_q;
      R_T4: v = t4_q;
      R_T5: v = t5_q;
      R_T6: v = t6_q;
      R_T7: v = t7_q;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop   = cmd_i.uop;
  assign a     = rd(uop.src_a);
  assign b     = rd(uop.src_b);
  assign add_r = sat_add(a, b);
  assign sub_r = sat_sub(a, b);

  always_comb begin
    unique case (uop.guard)
      G_POS:   guard_ok = cond_q;
      G_NEG:   guard_ok = !cond_q;
      default: guard_ok = 1'b1;
    endcase
  end

  always_comb begin
    alu_r.val = a;
    alu_r.ovf = 1'b0;
    case (uop.op)
      OP_ADD: alu_r = add_r;
      OP_SUB: alu_r = sub_r;
      OP_ABS: begin
        alu_r.ovf = (a == WMIN);
        alu_r.val = alu_r.ovf ? WMAX : (a[WORD_BITS-1] ? -a : a);
      end
      default: alu_r.val = a;
    endcase
  end

  // round half up at the binary point, then clamp to the word
  assign rnd = {prod_q[PROD_W-1], prod_q} + RND_W'(64'd1 << (FRAC_BITS - 1));
  assign shv = SH_W'(rnd >>> FRAC_BITS);
  always_comb begin
    mul_r.ovf = !((&shv[SH_W-1:WORD_BITS-1]) || !(|shv[SH_W-1:WORD_BITS-1]));
    mul_r.val = mul_r.ovf ? (shv[SH_W-1] ? WMIN : WMAX) : word_t'(shv[WORD_BITS-1:0]);
  end

  assign div_start = cmd_i.exec && uop.op == OP_DIV;

  ffs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (a),
    .den_i   (b),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  always_comb begin
    wr_en  = 1'b0;
    wr_sel = uop.dst;
    wr_val = alu_r.val;
    wr_ovf = 1'b0;
    priority if (div_done) begin
      wr_en  = 1'b1;
      wr_sel = dst_q;
      wr_val = div_quo;
      wr_ovf = div_sat;
    end else if (cmd_i.mul_wb) begin
      wr_en  = 1'b1;
      wr_sel = dst_q;
      wr_val = mul_r.val;
      wr_ovf = mul_r.ovf;
    end else if (cmd_i.exec) begin
      wr_en  = guard_ok && (uop.op == OP_ADD || uop.op == OP_SUB ||
                            uop.op == OP_ABS || uop.op == OP_MOV);
      wr_ovf = wr_en && alu_r.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q   <= F_MANDEL;
      qa_q     <= ONE_VAL;
      qb_q     <= ONE_VAL;
      qk_q     <= ONE_VAL;
      ovalid_q <= 1'b0;
      sat_q    <= 1'b0;
      div0_q   <= 1'b0;
      cond_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FSEL: fsel_q <= cfg_data_i[3:0];
          CFG_QA:   qa_q   <= cfg_data_i;
          CFG_QB:   qb_q   <= cfg_data_i;
          default:  qk_q   <= cfg_data_i;
        endcase
      end
      if (cmd_i.load) begin
        sat_q  <= 1'b0;
        div0_q <= 1'b0;
        cond_q <= 1'b0;
      end else begin
        if (wr_ovf) sat_q <= 1'b1;
        if (stat_o.abort) div0_q <= 1'b1;
        if (cmd_i.exec && uop.op == OP_TST) cond_q <= !a[WORD_BITS-1];
      end
      if (cmd_i.publish) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= z_real_in_i;
      y_q  <= z_imag_in_i;
      cx_q <= c_real_i;
      cy_q <= c_imag_i;
      sx_q <= sq_real_in_i;
      sy_q <= sq_imag_in_i;
    end else if (wr_en) begin
      case (wr_sel)
        R_X:  x_q  <= wr_val;
        R_Y:  y_q  <= wr_val;
        R_SX: sx_q <= wr_val;
        R_SY: sy_q <= wr_val;
        R_T0: t0_q <= wr_val;
        R_T1: t1_q <= wr_val;
        R_T2: t2_q <= wr_val;
        R_T3: t3_q <= wr_val;
        R_T4: t4_q <= wr_val;
        R_T5: t5_q <= wr_val;
        R_T6: t6_q <= wr_val;
        R_T7: t7_q <= wr_val;
        default: ;
      endcase
    end
    if (cmd_i.exec && (uop.op == OP_MUL || uop.op == OP_DIV)) dst_q <= uop.dst;
    if (cmd_i.exec && uop.op == OP_MUL) prod_q <= a * b;
    if (cmd_i.publish) begin
      zr_o_q <= x_q;
      zi_o_q <= y_q;
      sr_o_q <= sx_q;
      si_o_q <= sy_q;
      st_o_q <= div0_q ? STAT_DIV0 : (sat_q ? STAT_SAT : STAT_OK);
    end
  end

  always_comb begin
    stat_o.abort    = cmd_i.exec && uop.op == OP_NZ && (a[WORD_BITS-1] || a == '0);
    stat_o.div_done = div_done;
    stat_o.out_busy = ovalid_q && !out_ready_i;
    stat_o.fsel     = fsel_q;
  end

  assign z_real_out_o  = zr_o_q;
  assign z_imag_out_o  = zi_o_q;
  assign sq_real_out_o = sr_o_q;
  assign sq_imag_out_o = si_o_q;
  assign status_o      = st_o_q;
  assign out_valid_o   = ovalid_q;

endmodule
`default_nettype wire

### src/ffs_ctrl.sv
`default_nettype none
module ffs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            batch_mode_i,
  input  wire ffs_pkg::stat_t  stat_i,
  output ffs_pkg::cmd_t        cmd_o
);
  import ffs_pkg::*;

  state_e state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              batch_q, batch_d;
  logic [ITER_W-1:0] last_iter;
  uop_t              uop;
  logic              adv;

  assign uop       = ucode(stat_i.fsel, pc_q);
  assign last_iter = batch_q ? ITER_W'(BATCH_ITERS - 1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      iter_q  <= '0;
      batch_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      iter_q  <= iter_d;
      batch_q <= batch_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    iter_d      = iter_q;
    batch_d     = batch_q;
    adv         = 1'b0;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.uop   = uop;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = '0;
          iter_d     = '0;
          batch_d    = batch_mode_i;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.abort) state_d = S_DONE;
        else if (uop.op == OP_MUL) state_d = S_MUL;
        else if (uop.op == OP_DIV) state_d = S_DIV;
        else adv = 1'b1;
      end
      S_MUL: begin
        cmd_o.mul_wb = 1'b1;
        adv = 1'b1;
      end
      S_DIV: begin
        if (stat_i.div_done) adv = 1'b1;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (adv) begin
      state_d = S_EXEC;
      if (uop.last) begin
        pc_d = '0;
        if (iter_q == last_iter) state_d = S_DONE;
        else iter_d = iter_q + 1'b1;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/fractal_formula_step.sv
`default_nettype none
// Escape-time fractal step: applies one iteration (batch_mode 0) or eight
// (batch_mode 1) of the formula chosen by the CFG_FSEL register to z with constant c,
// in saturating Q4.28. One item at a time: a microcoded sequencer drives one
// 32x32 multiplier and a bit-serial divider. An unused selector runs no
// operations and leaves z unchanged. The result register lets the next item
// load while the last result waits.
module fractal_formula_step (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ffs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire ffs_pkg::word_t                 cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire ffs_pkg::word_t                 z_real_in_i,
  input  wire ffs_pkg::word_t                 z_imag_in_i,
  input  wire ffs_pkg::word_t                 c_real_i,
  input  wire ffs_pkg::word_t                 c_imag_i,
  input  wire ffs_pkg::word_t                 sq_real_in_i,
  input  wire ffs_pkg::word_t                 sq_imag_in_i,
  input  wire logic                           batch_mode_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output ffs_pkg::word_t                      z_real_out_o,
  output ffs_pkg::word_t                      z_imag_out_o,
  output ffs_pkg::word_t                      sq_real_out_o,
  output ffs_pkg::word_t                      sq_imag_out_o,
  output logic [1:0]                          status_o
);
  import ffs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ffs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .batch_mode_i (batch_mode_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  ffs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .z_real_in_i   (z_real_in_i),
    .z_imag_in_i   (z_imag_in_i),
    .c_real_i      (c_real_i),
    .c_imag_i      (c_imag_i),
    .sq_real_in_i  (sq_real_in_i),
    .sq_imag_in_i  (sq_imag_in_i),
    .z_real_out_o  (z_real_out_o),
    .z_imag_out_o  (z_imag_out_o),
    .sq_real_out_o (sq_real_out_o),
    .sq_imag_out_o (sq_imag_out_o),
    .status_o      (status_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK || status_o == STAT_SAT ||
                     status_o == STAT_DIV0))
    else $error("undefined status code");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !stat.out_busy)
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

### tb/sv/fractal_formula_step_checker.sv
`timescale 1ns / 100ps
module fractal_formula_step_checker
  import ffs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire word_t                 cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire word_t                 z_real_in_i,
  input  wire word_t                 z_imag_in_i,
  input  wire word_t                 c_real_i,
  input  wire word_t                 c_imag_i,
  input  wire word_t                 sq_real_in_i,
  input  wire word_t                 sq_imag_in_i,
  input  wire logic                  batch_mode_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire word_t                 z_real_out_i,
  input  wire word_t                 z_imag_out_i,
  input  wire word_t                 sq_real_out_i,
  input  wire word_t                 sq_imag_out_i,
  input  wire logic [1:0]            status_i,
  output int                         pending_o,
  output int                         fails_o
);

  typedef struct packed {
    word_t      zr;
    word_t      zi;
    word_t      sr;
    word_t      si;
    logic [1:0] st;
  } step_res_t;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;
  localparam longint LONE = 64'sd1 << FRAC_BITS;

  step_res_t  step_q[$];
  logic [3:0] fsel;
  longint     qa, qb, qk;
  bit         clamped;
  int         fail_cnt = 0;

  assign fails_o = fail_cnt;

  function automatic longint clamp(longint v);
    if (v > LMAX) begin
      clamped = 1;
      return LMAX;
    end
    if (v < LMIN) begin
      clamped = 1;
      return LMIN;
    end
    return v;
  endfunction

  function automatic longint fadd(longint a, longint b);
    return clamp(a + b);
  endfunction

  function automatic longint fsub(longint a, longint b);
    return clamp(a - b);
  endfunction

  function automatic longint fabs(longint a);
    return clamp(a < 0 ? -a : a);
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    p = (p + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clamp(p);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (m << FRAC_BITS) / d;
    if (q > LMAX) begin
      clamped = 1;
      return n < 0 ? LMIN : LMAX;
    end
    return n < 0 ? -q : q;
  endfunction

  // returns 1 on a zero Nova divisor, z untouched
  function automatic bit one_iter(inout longint x, inout longint y, input longint cx,
                                  input longint cy, inout longint sx, inout longint sy);
    longint a, b, x2, y2, nx, ny, tx, ty, xcy, xcx, ycy, ycx;
    longint zr2, zi2, z3r, z3i, nr, dr, di, den, qr, qi;
    bit pos;
    a = x;
    b = y;
    case (fsel)
      F_MANDEL, F_SHIP, F_BUFFALO, F_CUBIC, F_QUAD, F_LAMBDA: begin
        if (fsel == F_SHIP || fsel == F_BUFFALO) begin
          a = fabs(a);
          b = fabs(b);
        end
        x2 = fmul(a, a);
        y2 = fmul(b, b);
        sx = x2;
        sy = y2;
        case (fsel)
          F_MANDEL, F_SHIP: begin
            nx = fadd(fsub(x2, y2), cx);
            ny = fadd(fadd(fmul(a, b), fmul(a, b)), cy);
          end
          F_BUFFALO: begin
            nx = fadd(fsub(fsub(x2, y2), a), cx);
            tx = fmul(a, b);
            ny = fadd(fsub(fadd(tx, tx), b), cy);
          end
          F_CUBIC: begin
            tx = fmul(a, y2);
            ty = fmul(x2, b);
            nx = fadd(fsub(fmul(x2, a), fadd(fadd(tx, tx), tx)), cx);
            ny = fadd(fsub(fadd(fadd(ty, ty), ty), fmul(y2, b)), cy);
          end
          F_QUAD: begin
            nx = fadd(fadd(fmul(qa, fsub(x2, y2)), fmul(qb, a)), fmul(qk, cx));
            tx = fmul(a, b);
            ny = fadd(fadd(fmul(qa, fadd(tx, tx)), fmul(qb, b)), fmul(qk, cy));
          end
          default: begin
            tx = fadd(fsub(a, x2), y2);
            ty = fmul(a, b);
            ty = fsub(b, fadd(ty, ty));
            nx = fsub(fmul(cx, tx), fmul(cy, ty));
            ny = fadd(fmul(cx, ty), fmul(cy, tx));
          end
        endcase
      end
      F_BARN1, F_BARN2: begin
        xcy = fmul(a, cy);
        xcx = fmul(a, cx);
        ycy = fmul(b, cy);
        ycx = fmul(b, cx);
        pos = (fsel == F_BARN1) ? (a >= 0) : (fadd(xcy, ycx) >= 0);
        if (pos) begin
          nx = fsub(fsub(xcx, cx), ycy);
          ny = fadd(fsub(ycx, cy), xcy);
        end else begin
          nx = fsub(fadd(xcx, cx), ycy);
          ny = fadd(fadd(ycx, cy), xcy);
        end
      end
      F_NOVA: begin
        zr2 = fsub(fmul(a, a), fmul(b, b));
        zi2 = fmul(a, b);
        zi2 = fadd(zi2, zi2);
        z3r = fsub(fmul(zr2, a), fmul(zi2, b));
        z3i = fadd(fmul(zr2, b), fmul(zi2, a));
        nr = fsub(z3r, LONE);
        dr = fadd(fadd(zr2, zr2), zr2);
        di = fadd(fadd(zi2, zi2), zi2);
        den = fadd(fmul(dr, dr), fmul(di, di));
        if (den <= 0) return 1;
        qr = fdiv(fadd(fmul(nr, dr), fmul(z3i, di)), den);
        qi = fdiv(fsub(fmul(z3i, dr), fmul(nr, di)), den);
        nx = fadd(fsub(a, qr), cx);
        ny = fadd(fsub(b, qi), cy);
      end
      default: return 0;
    endcase
    x = nx;
    y = ny;
    return 0;
  endfunction

  function automatic step_res_t predict_step();
    longint x, y, cx, cy, sx, sy;
    int n;
    bit div0;
    step_res_t r;
    x = longint'(z_real_in_i);
    y = longint'(z_imag_in_i);
    cx = longint'(c_real_i);
    cy = longint'(c_imag_i);
    sx = longint'(sq_real_in_i);
    sy = longint'(sq_imag_in_i);
    n = batch_mode_i ? BATCH_ITERS : 1;
    div0 = 0;
    clamped = 0;
    for (int i = 0; i < n && !div0; i++) div0 = one_iter(x, y, cx, cy, sx, sy);
    r.zr = word_t'(x);
    r.zi = word_t'(y);
    r.sr = word_t'(sx);
    r.si = word_t'(sy);
    r.st = div0 ? STAT_DIV0 : (clamped ? STAT_SAT : STAT_OK);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_res_t e;
    if (!rst_ni) begin
      fsel <= F_MANDEL;
      qa <= LONE;
      qb <= LONE;
      qk <= LONE;
      pending_o <= 0;
      fail_cnt = 0;
      step_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (step_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          e = step_q.pop_front();
          if (z_real_out_i !== e.zr) report_mismatch("z_real", z_real_out_i, e.zr);
          if (z_imag_out_i !== e.zi) report_mismatch("z_imag", z_imag_out_i, e.zi);
          if (sq_real_out_i !== e.sr) report_mismatch("sq_real", sq_real_out_i, e.sr);
          if (sq_imag_out_i !== e.si) report_mismatch("sq_imag", sq_imag_out_i, e.si);
          if (status_i !== e.st) report_mismatch("status", status_i, e.st);
        end
      end
      if (in_valid_i && in_ready_i) step_q.push_back(predict_step());
      pending_o <= step_q.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FSEL: fsel <= cfg_data_i[3:0];
          CFG_QA:   qa <= longint'(cfg_data_i);
          CFG_QB:   qb <= longint'(cfg_data_i);
          default:  qk <= longint'(cfg_data_i);
        endcase
      end
    end
  end

endmodule

### tb/sv/fractal_formula_step_tb.sv
`timescale 1ns / 100ps
module fractal_formula_step_tb;
  import ffs_pkg::*;

  localparam int PHASES = 25;
  localparam int PER_PHASE = 28;
  localparam int CYCLE_LIMIT = 10000000;

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_FSEL;
  word_t                cfg_data = '0;
  logic                 in_valid = 0;
  logic                 in_ready;
  word_t                zr = '0, zi = '0, cr = '0, ci = '0, sr = '0, si = '0;
  logic                 batch = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  word_t                zr_o, zi_o, sr_o, si_o;
  logic [1:0]           status;
  int                   pending, fails;
  int                   phase = 0;
  int                   cycles = 0;

  always #5 clk_i = ~clk_i;

  fractal_formula_step u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .z_real_in_i(zr), .z_imag_in_i(zi), .c_real_i(cr), .c_imag_i(ci),
    .sq_real_in_i(sr), .sq_imag_in_i(si), .batch_mode_i(batch),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .z_real_out_o(zr_o), .z_imag_out_o(zi_o), .sq_real_out_o(sr_o),
    .sq_imag_out_o(si_o), .status_o(status)
  );

  fractal_formula_step_checker u_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .z_real_in_i(zr), .z_imag_in_i(zi), .c_real_i(cr), .c_imag_i(ci),
    .sq_real_in_i(sr), .sq_imag_in_i(si), .batch_mode_i(batch),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .z_real_out_i(zr_o), .z_imag_out_i(zi_o), .sq_real_out_i(sr_o),
    .sq_imag_out_i(si_o), .status_i(status),
    .pending_o(pending), .fails_o(fails)
  );

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return WMAX;
      1: return WMIN;
      2: return '0;
      3: return word_t'($urandom);
      default: return word_t'(longint'($urandom_range(0, 1 << 30)) - (64'sd1 << 29));
    endcase
  endfunction

  task automatic send_beat(word_t a, word_t b, word_t c, word_t d, word_t e, word_t f,
                           logic bm);
    int gap;
    gap = (phase % 3 == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    zr <= a; zi <= b; cr <= c; ci <= d; sr <= e; si <= f; batch <= bm;
    in_valid <= 1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver, with one long hold-off early on
  initial begin
    int stall, got;
    got = 0;
    @(posedge rst_ni);
    forever begin
      if (got == 10) stall = 400;
      else if ((got / 50) % 2 == 1) stall = 0;
      else stall = $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1;
      do @(posedge clk_i); while (!out_valid);
      got++;
    end
  end

  initial begin
    word_t a, b;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // extremes under reset settings
    send_beat(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 1'b0);
    send_beat(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 1'b1);
    send_beat('0, '0, '0, '0, '0, '0, 1'b0);
    send_beat(WMIN, WMAX, '0, WMIN, WMAX, WMIN, 1'b0);
    send_beat(word_t'(-1), word_t'(1), word_t'(-1), word_t'(1), '0, word_t'(-1), 1'b1);
    send_beat(word_t'(32'h1000_0000), word_t'(32'hf000_0000), '0, '0, '0, '0, 1'b1);
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        write_reg(CFG_FSEL, phase < 18 ? phase % 9 : 9 + (phase - 18));
        if (phase == 13) begin
          write_reg(CFG_QA, WMAX);
          write_reg(CFG_QB, WMIN);
          write_reg(CFG_QK, '0);
        end else begin
          write_reg(CFG_QA, pick_word());
          write_reg(CFG_QB, pick_word());
          write_reg(CFG_QK, pick_word());
        end
      end
      for (int i = 0; i < PER_PHASE; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          a = '0;
          b = '0;
        end else begin
          a = pick_word();
          b = pick_word();
        end
        send_beat(a, b, pick_word(), pick_word(), word_t'($urandom), word_t'($urandom),
                  1'($urandom));
      end
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
